FILE: sv/vud_pkg.sv
package vud_pkg;

    // number of samples averaged into the baseline
    localparam int CAL_SAMPLES = 16;

    // calibration counter holds 0 .. CAL_SAMPLES
    localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
    // shift that turns the sum into the average, floor(log2(CAL_SAMPLES))
    localparam int CAL_SHIFT = $clog2(CAL_SAMPLES + 1) - 1;

    // sample, limit and result field widths
    localparam int SAMPLE_W = 15;
    localparam int LIMIT_W  = 16;
    localparam int BASE_W   = 19;
    localparam int COUNT_W  = 8;

    // accumulator wide enough for CAL_SAMPLES full-scale samples
    localparam int ACC_W = SAMPLE_W + $clog2(CAL_SAMPLES);
    // signed compare width for sample against baseline plus limit
    localparam int CMP_W = ACC_W + 2;

    localparam logic signed [LIMIT_W-1:0] PEAK_START = -16'sd32000;

    localparam int NUM_AXES = 3;

    // configuration port
    localparam int NUM_REGS = 6;
    localparam int ADDR_W   = $clog2(4 * NUM_REGS);
    localparam int IDX_W    = ADDR_W - 2;
    localparam int DATA_W   = 32;

    localparam logic [IDX_W-1:0] REG_HIT_THR  = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_CRIT_THR = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_X_LIMIT  = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_Y_LIMIT  = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_Z_LIMIT  = IDX_W'(4);
    localparam logic [IDX_W-1:0] REG_DET_EN   = IDX_W'(5);

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_FLAG   = 2'd2
    } cmd_t;

endpackage

FILE: sv/vibration_unbalance_detector.sv
// vibration unbalance detector
//
// input channel (in_valid / in_ready) carries one word per command: a
// three-axis absolute acceleration sample, a hit counter clear, or a write
// of the unbalance flag. every accepted word produces exactly one result
// word on the output channel (out_valid / out_ready) that reports the state
// after that command: flag, calibration status, hit sum, critical hits,
// per-axis peaks and the baseline (or the running sums while calibrating).
// out_valid rises in the cycle after acceptance; with no stall, one word per
// cycle is sustained because the whole state update is a single pass of
// compares and small adds ahead of the state registers, which also serve
// as the result register. when the receiver stalls, the result holds and
// in_ready drops until it is taken; a word can be accepted in the same
// cycle a result leaves. thresholds, limits and the detection enable sit
// behind a small apb port, written while no word is in flight.
// reset clears all state and the result register: peaks start at -32000,
// detection is enabled, all thresholds and limits are zero, and the first
// CAL_SAMPLES samples form the baseline again.
module vibration_unbalance_detector (
    input  logic                         clk,
    input  logic                         rst_n,
    // apb configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [vud_pkg::ADDR_W-1:0]   paddr,
    input  logic [vud_pkg::DATA_W-1:0]   pwdata,
    output logic [vud_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    // input words
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   cmd,
    input  logic [14:0]                  sample_x,
    input  logic [14:0]                  sample_y,
    input  logic [14:0]                  sample_z,
    input  logic                         flag_value,
    // result words
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         unbalance,
    output logic                         calibrated,
    output logic [7:0]                   hit_sum,
    output logic [7:0]                   critical_hits,
    output logic signed [15:0]           peak_x,
    output logic signed [15:0]           peak_y,
    output logic signed [15:0]           peak_z,
    output logic [18:0]                  base_x,
    output logic [18:0]                  base_y,
    output logic [18:0]                  base_z
);

    import vud_pkg::*;

    // configuration registers
    logic [COUNT_W-1:0]        hit_thr_reg;
    logic [COUNT_W-1:0]        crit_thr_reg;
    logic signed [LIMIT_W-1:0] limit_reg [NUM_AXES];
    logic                      det_en_reg;

    // detector state
    logic [CNT_W-1:0]          cal_count_reg, cal_count_next;
    logic [ACC_W-1:0]          acc_reg   [NUM_AXES];
    logic [ACC_W-1:0]          acc_next  [NUM_AXES];
    logic [SAMPLE_W-1:0]       high_reg  [NUM_AXES];
    logic [SAMPLE_W-1:0]       high_next [NUM_AXES];
    logic signed [LIMIT_W-1:0] peak_reg  [NUM_AXES];
    logic signed [LIMIT_W-1:0] peak_next [NUM_AXES];
    logic [COUNT_W-1:0]        hits_reg  [NUM_AXES];
    logic [COUNT_W-1:0]        hits_next [NUM_AXES];
    logic [COUNT_W-1:0]        crit_reg, crit_next;
    logic [COUNT_W-1:0]        sum_reg, sum_next;
    logic                      armed_reg, armed_next;
    logic                      flag_reg, flag_next;
    logic                      out_valid_reg, out_valid_next;

    // per-item working signals
    logic [SAMPLE_W-1:0]       smp       [NUM_AXES];
    logic [ACC_W-1:0]          acc_sum   [NUM_AXES];
    logic [ACC_W-1:0]          acc_avg   [NUM_AXES];
    logic signed [CMP_W-1:0]   smp_ext   [NUM_AXES];
    logic signed [CMP_W-1:0]   bound     [NUM_AXES];
    logic [NUM_AXES-1:0]       exceed;
    logic [COUNT_W-1:0]        crit_inc;
    logic                      is_cal;
    logic                      in_fire;
    logic                      cfg_write;
    logic [IDX_W-1:0]          cfg_idx;

    // apb access

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[ADDR_W-1:2];

    always_comb
    begin
        unique case (cfg_idx)
            REG_HIT_THR:  prdata = DATA_W'(hit_thr_reg);
            REG_CRIT_THR: prdata = DATA_W'(crit_thr_reg);
            REG_X_LIMIT:  prdata = DATA_W'(limit_reg[0]);
            REG_Y_LIMIT:  prdata = DATA_W'(limit_reg[1]);
            REG_Z_LIMIT:  prdata = DATA_W'(limit_reg[2]);
            REG_DET_EN:   prdata = DATA_W'(det_en_reg);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_thr_reg  <= '0;
            crit_thr_reg <= '0;
            limit_reg[0] <= '0;
            limit_reg[1] <= '0;
            limit_reg[2] <= '0;
            det_en_reg   <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_HIT_THR:  hit_thr_reg  <= pwdata[COUNT_W-1:0];
                REG_CRIT_THR: crit_thr_reg <= pwdata[COUNT_W-1:0];
                REG_X_LIMIT:  limit_reg[0] <= $signed(pwdata[LIMIT_W-1:0]);
                REG_Y_LIMIT:  limit_reg[1] <= $signed(pwdata[LIMIT_W-1:0]);
                REG_Z_LIMIT:  limit_reg[2] <= $signed(pwdata[LIMIT_W-1:0]);
                REG_DET_EN:   det_en_reg   <= pwdata[0];
                default:      ;
            endcase
        end
    end

    // handshake: the state registers double as the result register, so a
    // new word may enter whenever the current result is gone or leaving

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    assign is_cal = (cal_count_reg >= CNT_W'(CAL_SAMPLES));

    assign smp[0] = sample_x;
    assign smp[1] = sample_y;
    assign smp[2] = sample_z;

    // per-axis arithmetic, axes are independent
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            acc_sum[a] = acc_reg[a] + ACC_W'(smp[a]);
            acc_avg[a] = acc_sum[a] >> CAL_SHIFT;
            smp_ext[a] = $signed({{(CMP_W-SAMPLE_W){1'b0}}, smp[a]});
            // baseline plus limit, signed
            bound[a]   = $signed({2'b00, acc_reg[a]})
                       + $signed({{(CMP_W-LIMIT_W){limit_reg[a][LIMIT_W-1]}}, limit_reg[a]});
            exceed[a]  = smp_ext[a] > bound[a];
        end
    end

    assign crit_inc = crit_reg + COUNT_W'(1);

    // next state for the accepted word
    always_comb
    begin
        logic done;

        done           = 1'b0;
        cal_count_next = cal_count_reg;
        crit_next      = crit_reg;
        sum_next       = sum_reg;
        armed_next     = armed_reg;
        flag_next      = flag_reg;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            acc_next[a]  = acc_reg[a];
            high_next[a] = high_reg[a];
            peak_next[a] = peak_reg[a];
            hits_next[a] = hits_reg[a];
        end

        unique case (cmd)
            CMD_SAMPLE:
            begin
                if (!is_cal)
                begin
                    // calibration: accumulate, average on the last sample
                    cal_count_next = cal_count_reg + CNT_W'(1);
                    for (int a = 0; a < NUM_AXES; a++)
                    begin
                        acc_next[a] = acc_sum[a];
                    end
                    if (cal_count_reg == CNT_W'(CAL_SAMPLES - 1))
                    begin
                        for (int a = 0; a < NUM_AXES; a++)
                        begin
                            acc_next[a]  = acc_avg[a];
                            high_next[a] = acc_avg[a][SAMPLE_W-1:0];
                        end
                    end
                end
                else
                begin
                    // peak compare is signed, the sample is zero-extended
                    for (int a = 0; a < NUM_AXES; a++)
                    begin
                        if ($signed({1'b0, smp[a]}) > peak_reg[a])
                        begin
                            peak_next[a] = $signed({1'b0, smp[a]});
                        end
                    end

                    if ((|exceed) && armed_reg)
                    begin
                        if ((crit_inc >= crit_thr_reg) && det_en_reg)
                        begin
                            // latch unbalance and start over
                            for (int a = 0; a < NUM_AXES; a++)
                            begin
                                hits_next[a] = '0;
                            end
                            crit_next  = '0;
                            flag_next  = 1'b1;
                            armed_next = 1'b0;
                        end
                        else
                        begin
                            crit_next = crit_inc;
                        end
                    end
                    else
                    begin
                        // priority chain, x before y before z, new high first
                        for (int a = 0; a < NUM_AXES; a++)
                        begin
                            if (!done)
                            begin
                                if (smp[a] > high_reg[a])
                                begin
                                    high_next[a] = smp[a];
                                    hits_next[a] = hits_reg[a] + COUNT_W'(1);
                                    done         = 1'b1;
                                end
                                else if (exceed[a])
                                begin
                                    hits_next[a] = hits_reg[a] + COUNT_W'(2);
                                    done         = 1'b1;
                                end
                            end
                        end
                    end

                    sum_next = hits_next[0] + hits_next[1] + hits_next[2];
                    if (sum_next > hit_thr_reg)
                    begin
                        armed_next = 1'b1;
                    end
                end
            end
            CMD_CLEAR:
            begin
                for (int a = 0; a < NUM_AXES; a++)
                begin
                    hits_next[a] = '0;
                    high_next[a] = acc_reg[a][SAMPLE_W-1:0];
                end
                crit_next  = '0;
                armed_next = 1'b0;
            end
            CMD_FLAG:
            begin
                flag_next = flag_value;
            end
            default:
            begin
                // unused command, state unchanged
            end
        endcase
    end

    always_comb
    begin
        if (in_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cal_count_reg <= '0;
            crit_reg      <= '0;
            sum_reg       <= '0;
            armed_reg     <= 1'b0;
            flag_reg      <= 1'b0;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                acc_reg[a]  <= '0;
                high_reg[a] <= '0;
                peak_reg[a] <= PEAK_START;
                hits_reg[a] <= '0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_fire)
            begin
                cal_count_reg <= cal_count_next;
                crit_reg      <= crit_next;
                sum_reg       <= sum_next;
                armed_reg     <= armed_next;
                flag_reg      <= flag_next;
                for (int a = 0; a < NUM_AXES; a++)
                begin
                    acc_reg[a]  <= acc_next[a];
                    high_reg[a] <= high_next[a];
                    peak_reg[a] <= peak_next[a];
                    hits_reg[a] <= hits_next[a];
                end
            end
        end
    end

    // result word straight from the state registers

    assign unbalance     = flag_reg;
    assign calibrated    = is_cal;
    assign hit_sum       = sum_reg;
    assign critical_hits = crit_reg;
    assign peak_x        = peak_reg[0];
    assign peak_y        = peak_reg[1];
    assign peak_z        = peak_reg[2];
    assign base_x        = BASE_W'(acc_reg[0]);
    assign base_y        = BASE_W'(acc_reg[1]);
    assign base_z        = BASE_W'(acc_reg[2]);

`ifndef ASSERT_OFF
    // a stalled result must not change under the receiver
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=>
            ($stable(crit_reg) && $stable(sum_reg) && $stable(flag_reg)
             && $stable(cal_count_reg)))
        else $error("result changed while stalled");

    // every accepted word yields a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted word produced no result");

    // calibration completes once and stays complete
    assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(is_cal))
        else $error("calibration status dropped");

    // counters stay clear until the baseline exists
    assert property (@(posedge clk) disable iff (!rst_n)
        !is_cal |-> (crit_reg == '0 && hits_reg[0] == '0
                     && hits_reg[1] == '0 && hits_reg[2] == '0))
        else $error("hit counters moved before calibration");

    // a latch from a sample always clears the critical count
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && cmd == CMD_SAMPLE) ##1 $rose(flag_reg) |-> (crit_reg == '0))
        else $error("critical count not cleared on latch");
`endif

endmodule

FILE: dv/vibration_unbalance_detector_test.sv
module vibration_unbalance_detector_test;

    import vud_pkg::*;

    // opcode that the block leaves without effect
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // floor(log2) of the calibration length
    localparam int AVG_SHIFT = $clog2(CAL_SAMPLES + 1) - 1;
    localparam logic signed [15:0] PEAK_RESET = -16'sd32000;

    localparam int DRAIN_CYCLES    = 4;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int MAX_REPORTS     = 10;

    // one result word, packed so it sits in a queue
    typedef struct packed {
        logic            unbalance;
        logic            calibrated;
        logic [7:0]      hit_sum;
        logic [7:0]      critical_hits;
        logic [2:0][15:0] peak;
        logic [2:0][18:0] base;
    } status_t;

    // every input is known from time zero
    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                psel       = 1'b0;
    logic                penable    = 1'b0;
    logic                pwrite     = 1'b0;
    logic [ADDR_W-1:0]   paddr      = '0;
    logic [DATA_W-1:0]   pwdata     = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid   = 1'b0;
    logic                in_ready;
    logic [1:0]          cmd        = '0;
    logic [14:0]         sample_x   = '0;
    logic [14:0]         sample_y   = '0;
    logic [14:0]         sample_z   = '0;
    logic                flag_value = 1'b0;
    logic                out_valid;
    logic                out_ready  = 1'b0;
    logic                unbalance;
    logic                calibrated;
    logic [7:0]          hit_sum;
    logic [7:0]          critical_hits;
    logic signed [15:0]  peak_x;
    logic signed [15:0]  peak_y;
    logic signed [15:0]  peak_z;
    logic [18:0]         base_x;
    logic [18:0]         base_y;
    logic [18:0]         base_z;

    vibration_unbalance_detector dut (.*);

    always #4 clk = ~clk;

    // detector state as the testbench sees it
    int                 cal_seen = 0;
    logic [19:0]        acc_sum [NUM_AXES]      = '{default: '0};
    logic [14:0]        run_high [NUM_AXES]     = '{default: '0};
    logic signed [15:0] axis_peak [NUM_AXES]    = '{default: PEAK_RESET};
    logic [7:0]         axis_hit_cnt [NUM_AXES] = '{default: '0};
    logic [7:0]         crit_cnt      = '0;
    logic [7:0]         hit_total     = '0;
    logic               crit_armed    = 1'b0;
    logic               flag_latched  = 1'b0;

    // register copies, reset values
    logic [7:0]         thr_hits = '0;
    logic [7:0]         thr_crit = '0;
    logic signed [15:0] axis_limit [NUM_AXES] = '{default: '0};
    logic               detect_on = 1'b1;

    // results still owed by the block, oldest first
    status_t pending_status [$];

    int fail_count     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int stall_request  = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    // advance the detector by one word and return the status it reports
    function automatic status_t next_status(logic [1:0] c, logic [14:0] sx, logic [14:0] sy,
                                            logic [14:0] sz, logic fv);
        logic [14:0] lvl [NUM_AXES];
        logic        over [NUM_AXES];
        logic        any_over;
        logic        taken;
        status_t     st;
        lvl[0] = sx;
        lvl[1] = sy;
        lvl[2] = sz;
        any_over = 1'b0;
        taken = 1'b0;
        case (c)
            CMD_SAMPLE:
            begin
                if (cal_seen < CAL_SAMPLES)
                begin
                    // still calibrating: only the sums move
                    cal_seen++;
                    for (int a = 0; a < NUM_AXES; a++)
                        acc_sum[a] += 20'(lvl[a]);
                    if (cal_seen == CAL_SAMPLES)
                    begin
                        for (int a = 0; a < NUM_AXES; a++)
                        begin
                            acc_sum[a] = acc_sum[a] >> AVG_SHIFT;
                            run_high[a] = acc_sum[a][14:0];
                        end
                    end
                end
                else
                begin
                    for (int a = 0; a < NUM_AXES; a++)
                    begin
                        if (int'(lvl[a]) > int'(axis_peak[a]))
                            axis_peak[a] = {1'b0, lvl[a]};
                        over[a] = int'(lvl[a]) > int'(acc_sum[a]) + int'(axis_limit[a]);
                        any_over |= over[a];
                    end
                    if (any_over && crit_armed)
                    begin
                        crit_cnt += 8'd1;
                        if (crit_cnt >= thr_crit && detect_on)
                        begin
                            for (int a = 0; a < NUM_AXES; a++)
                                axis_hit_cnt[a] = '0;
                            crit_cnt = '0;
                            flag_latched = 1'b1;
                            crit_armed = 1'b0;
                        end
                    end
                    else
                    begin
                        // priority chain, x first: new high, then excess
                        for (int a = 0; a < NUM_AXES; a++)
                        begin
                            if (!taken)
                            begin
                                if (lvl[a] > run_high[a])
                                begin
                                    run_high[a] = lvl[a];
                                    axis_hit_cnt[a] += 8'd1;
                                    taken = 1'b1;
                                end
                                else if (over[a])
                                begin
                                    axis_hit_cnt[a] += 8'd2;
                                    taken = 1'b1;
                                end
                            end
                        end
                    end
                    hit_total = axis_hit_cnt[0] + axis_hit_cnt[1] + axis_hit_cnt[2];
                    if (hit_total > thr_hits)
                        crit_armed = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                // hit_total is left alone until the next sample
                for (int a = 0; a < NUM_AXES; a++)
                begin
                    axis_hit_cnt[a] = '0;
                    run_high[a] = acc_sum[a][14:0];
                end
                crit_cnt = '0;
                crit_armed = 1'b0;
            end
            CMD_FLAG:
                flag_latched = fv;
            default:
                ;
        endcase
        st.unbalance = flag_latched;
        st.calibrated = (cal_seen >= CAL_SAMPLES);
        st.hit_sum = hit_total;
        st.critical_hits = crit_cnt;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            st.peak[a] = axis_peak[a];
            st.base[a] = acc_sum[a][18:0];
        end
        return st;
    endfunction

    // sample level: mostly near the baseline, some full range, some near full scale
    function automatic logic [14:0] pick_level(int axis, int spread);
        int mode;
        int lvl;
        mode = $urandom_range(99);
        if (mode < 20)
            lvl = $urandom_range(32767);
        else if (mode < 30)
            lvl = $urandom_range(32767, 30000);
        else
            lvl = int'(acc_sum[axis]) + int'($urandom_range(2 * spread)) - spread;
        if (lvl < 0)
            lvl = 0;
        else if (lvl > 32767)
            lvl = 32767;
        return lvl[14:0];
    endfunction

    task automatic note_failure(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("mismatch: %s", msg);
    endtask

    task automatic check_field(string name, logic signed [63:0] want_v,
                               logic signed [63:0] got_v);
        if (want_v !== got_v)
            note_failure($sformatf("%s expected %0d, got %0d", name, want_v, got_v));
    endtask

    // one word on the input channel; valid stays up until taken
    task automatic send_word(input logic [1:0] c, input logic [14:0] sx,
                             input logic [14:0] sy, input logic [14:0] sz, input logic fv);
        int gap;
        @(negedge clk);
        if ($urandom_range(99) < send_idle_pct)
        begin
            gap = $urandom_range(3, 1);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd        <= c;
        sample_x   <= sx;
        sample_y   <= sy;
        sample_z   <= sz;
        flag_value <= fv;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_status.push_back(next_status(c, sx, sy, sz, fv));
    endtask

    // mostly samples, with clears, flag writes and the dead opcode mixed in
    task automatic send_random_word(int clear_pct, int spread);
        int         roll;
        logic [1:0] c;
        roll = $urandom_range(99);
        if (roll < clear_pct)
            c = CMD_CLEAR;
        else if (roll < clear_pct + 3)
            c = CMD_FLAG;
        else if (roll < clear_pct + 5)
            c = CMD_UNUSED;
        else
            c = CMD_SAMPLE;
        send_word(c, pick_level(0, spread), pick_level(1, spread), pick_level(2, spread),
                  1'($urandom_range(1)));
    endtask

    // drop valid, let every owed result come back, then a few spare cycles
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // apb write: setup then access, register lands when pready is seen
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_HIT_THR:  thr_hits = value[7:0];
            REG_CRIT_THR: thr_crit = value[7:0];
            REG_X_LIMIT:  axis_limit[0] = value[15:0];
            REG_Y_LIMIT:  axis_limit[1] = value[15:0];
            REG_Z_LIMIT:  axis_limit[2] = value[15:0];
            REG_DET_EN:   detect_on = value[0];
            default:      ;
        endcase
    endtask

    task automatic apply_config(logic [7:0] hit, logic [7:0] crit, logic signed [15:0] lx,
                                logic signed [15:0] ly, logic signed [15:0] lz, logic det);
        write_reg(REG_HIT_THR, 32'(hit));
        write_reg(REG_CRIT_THR, 32'(crit));
        write_reg(REG_X_LIMIT, 32'(lx));
        write_reg(REG_Y_LIMIT, 32'(ly));
        write_reg(REG_Z_LIMIT, 32'(lz));
        write_reg(REG_DET_EN, 32'(det));
    endtask

    task automatic set_idle(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic run_phase(int words, int clear_pct, int spread);
        repeat (words) send_random_word(clear_pct, spread);
        wait_drained();
    endtask

    // calibration window: extremes, a clear on partial sums, dead opcode, flag writes
    task automatic test_calibration();
        send_word(CMD_SAMPLE, 15'h7fff, 15'h7fff, 15'h7fff, 1'b0);
        send_word(CMD_SAMPLE, 15'h0000, 15'h0000, 15'h0000, 1'b1);
        send_word(CMD_CLEAR, 15'h1111, 15'h2222, 15'h3333, 1'b0);
        send_word(CMD_UNUSED, 15'h7fff, 15'h0000, 15'h5555, 1'b1);
        send_word(CMD_FLAG, 15'h0000, 15'h7fff, 15'h2aaa, 1'b1);
        send_word(CMD_SAMPLE, 15'h2aaa, 15'h5555, 15'h1234, 1'b0);
        send_word(CMD_FLAG, 15'h5555, 15'h2aaa, 15'h0000, 1'b0);
        repeat (CAL_SAMPLES - 3)
            send_word(CMD_SAMPLE, 15'($urandom_range(9000, 3000)),
                      15'($urandom_range(9000, 3000)), 15'($urandom_range(9000, 3000)), 1'b0);
        wait_drained();
    endtask

    // reset register values: zero critical threshold latches on the first critical hit
    task automatic test_first_detection();
        send_word(CMD_SAMPLE, 15'h7fff, 15'h7fff, 15'h7fff, 1'b0);
        send_word(CMD_SAMPLE, 15'h7fff, 15'h0000, 15'h0000, 1'b0);
        send_word(CMD_CLEAR, 15'h0000, 15'h0000, 15'h0000, 1'b0);
        send_word(CMD_FLAG, 15'h0000, 15'h0000, 15'h0000, 1'b0);
        send_word(CMD_SAMPLE, 15'h0000, 15'h0000, 15'h0000, 1'b0);
        wait_drained();
    endtask

    // moderate thresholds, both sides streaming
    task automatic test_steady_detection();
        set_idle(0, 0);
        apply_config(8'd8, 8'd4, 16'sd200, 16'sd300, 16'sd400, 1'b1);
        run_phase(150, 6, 600);
    endtask

    // every critical hit latches straight away
    task automatic test_instant_latch();
        set_idle(67, 0);
        apply_config(8'd0, 8'd0, 16'sd0, 16'sd0, 16'sd0, 1'b1);
        run_phase(160, 6, 400);
    endtask

    // never arms, every sample counts, so the hit sum wraps
    task automatic test_hit_wrap();
        set_idle(0, 67);
        apply_config(8'd255, 8'd255, -16'sd32768, -16'sd32768, -16'sd32768, 1'b1);
        run_phase(160, 0, 400);
    endtask

    // detection off while always armed: critical count wraps
    task automatic test_critical_wrap();
        set_idle(25, 25);
        apply_config(8'd0, 8'd255, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0);
        run_phase(300, 0, 400);
    endtask

    // limits at the top, only new highs score
    task automatic test_quiet_axes();
        set_idle(0, 0);
        apply_config(8'd20, 8'd1, 16'sd32767, 16'sd32767, 16'sd32767, 1'b1);
        run_phase(150, 5, 800);
    endtask

    // long receiver hold-off fills the block, then the sender waits it out
    task automatic test_backpressure();
        set_idle(0, 0);
        stall_request = HOLD_OFF_CYCLES;
        repeat (12) send_random_word(6, 500);
        wait_drained();
        repeat (12) send_random_word(6, 500);
        wait_drained();
    endtask

    // random thresholds and limits under each idling mix
    task automatic test_random_settings();
        for (int k = 0; k < 3; k++)
        begin
            case (k)
                0:       set_idle(67, 0);
                1:       set_idle(0, 67);
                default: set_idle(25, 25);
            endcase
            apply_config(8'($urandom_range(40)), 8'($urandom_range(6)),
                         16'(int'($urandom_range(3000)) - 1000),
                         16'(int'($urandom_range(3000)) - 1000),
                         16'(int'($urandom_range(3000)) - 1000), 1'($urandom_range(1)));
            run_phase(150, 5, int'($urandom_range(2000, 200)));
        end
    endtask

    // receiver: random stalls, or a counted hold-off when one is requested
    always @(negedge clk)
    begin
        if (stall_request > 0)
        begin
            hold_left = stall_request;
            stall_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // compare each result word with the oldest owed status
    always @(posedge clk)
    begin : check_results
        status_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_status.size() == 0)
                note_failure("result word with nothing owed");
            else
            begin
                want = pending_status.pop_front();
                check_field("unbalance", want.unbalance, unbalance);
                check_field("calibrated", want.calibrated, calibrated);
                check_field("hit_sum", want.hit_sum, hit_sum);
                check_field("critical_hits", want.critical_hits, critical_hits);
                check_field("peak_x", $signed(want.peak[0]), peak_x);
                check_field("peak_y", $signed(want.peak[1]), peak_y);
                check_field("peak_z", $signed(want.peak[2]), peak_z);
                check_field("base_x", want.base[0], base_x);
                check_field("base_y", want.base[1], base_y);
                check_field("base_z", want.base[2], base_z);
            end
        end
    end

    // watchdog: too long without any word moving on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("vibration_unbalance_detector regression: fail");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_calibration();
        test_first_detection();
        test_steady_detection();
        test_instant_latch();
        test_hit_wrap();
        test_critical_wrap();
        test_quiet_axes();
        test_backpressure();
        test_random_settings();
        wait_drained();
        if (fail_count == 0 && pending_status.size() == 0)
            $display("vibration_unbalance_detector regression: pass");
        else
            $display("vibration_unbalance_detector regression: fail");
        $finish;
    end

endmodule

FILE: filelist.f
sv/vud_pkg.sv
sv/vibration_unbalance_detector.sv
dv/vibration_unbalance_detector_test.sv
